@@ rtl/core/shelf_atlas_allocator_macros.svh @@
// Assertion macros for the shelf atlas allocator checker.
// Expects signals named clk and rst in the scope where a macro is used.
`ifndef SHELF_ATLAS_ALLOCATOR_MACROS_SVH
`define SHELF_ATLAS_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SAT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/sat_pkg.sv @@
// Shared types, constants and helpers of the shelf atlas allocator.
// No dependencies; sat_req_if, sat_res_if, sat_ctrl, the top level and sat_checker import it.
package sat_pkg;

  localparam int MAX_ROWS = 256;
  localparam int MAX_SIDE = 16384;

  localparam int ROW_AW = $clog2(MAX_ROWS);
  localparam int CNT_W  = $clog2(MAX_ROWS + 1);

  localparam int SIDE_W = 15;
  localparam int PAD_W  = 14;
  localparam int POS_W  = 14;
  localparam int FILL_W = 16;
  localparam int PAD_SZ_W = SIDE_W + 1;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 15;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] REG_MAX_W   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_MAX_H   = 3'd1;
  localparam logic [CFG_AW-1:0] REG_START_W = 3'd2;
  localparam logic [CFG_AW-1:0] REG_START_H = 3'd3;
  localparam logic [CFG_AW-1:0] REG_PAD     = 3'd4;

  // register reset values
  localparam logic [SIDE_W-1:0] MAX_W_RST   = 15'd4096;
  localparam logic [SIDE_W-1:0] MAX_H_RST   = 15'd4096;
  localparam logic [SIDE_W-1:0] START_W_RST = 15'd32;
  localparam logic [SIDE_W-1:0] START_H_RST = 15'd32;
  localparam logic [PAD_W-1:0]  PAD_RST     = 14'd1;

  // result status codes
  localparam logic [1:0] ST_PLACED = 2'd0;
  localparam logic [1:0] ST_AT_MAX = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic [SIDE_W-1:0] top;
    logic [SIDE_W-1:0] tall;
    logic [FILL_W-1:0] fill;
  } row_t;

  typedef struct packed {
    logic [SIDE_W-1:0] max_width;
    logic [SIDE_W-1:0] max_height;
    logic [PAD_W-1:0]  pad_amount;
    logic              load_w;
    logic              load_h;
    logic [SIDE_W-1:0] load_value;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [SIDE_W-1:0] cur_width;
    logic [SIDE_W-1:0] cur_height;
    logic [SIDE_W-1:0] used_height;
  } res_t;

  // clamp a maximum register to the hard side limit
  function automatic logic [SIDE_W-1:0] lim(input logic [SIDE_W-1:0] r);
    logic [SIDE_W+1:0] rx;
    logic [SIDE_W+1:0] mx;
    rx = {2'b00, r};
    mx = (SIDE_W + 2)'(MAX_SIDE);
    return (rx < mx) ? r : mx[SIDE_W-1:0];
  endfunction

  // double a side, clamped to its maximum
  function automatic logic [SIDE_W-1:0] grow_side(input logic [SIDE_W-1:0] side,
                                                  input logic [SIDE_W-1:0] mx);
    logic [SIDE_W:0] d;
    d = {side, 1'b0};
    return (d < {1'b0, mx}) ? d[SIDE_W-1:0] : mx;
  endfunction

endpackage

@@ rtl/core/sat_req_if.sv @@
// Request channel of the shelf atlas allocator: valid/ready plus rectangle size.
// Depends on sat_pkg.
interface sat_req_if;
  import sat_pkg::*;

  logic              valid;
  logic              ready;
  logic [SIDE_W-1:0] rect_width;
  logic [SIDE_W-1:0] rect_height;

  modport source (output valid, output rect_width, output rect_height, input ready);
  modport sink   (input valid, input rect_width, input rect_height, output ready);
endinterface

@@ rtl/core/sat_res_if.sv @@
// Result channel of the shelf atlas allocator: valid/ready plus placement result.
// Depends on sat_pkg.
interface sat_res_if;
  import sat_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [POS_W-1:0]  pos_x;
  logic [POS_W-1:0]  pos_y;
  logic [SIDE_W-1:0] cur_width;
  logic [SIDE_W-1:0] cur_height;
  logic [SIDE_W-1:0] used_height;

  modport source (output valid, output status, output pos_x, output pos_y,
                  output cur_width, output cur_height, output used_height,
                  input ready);
  modport sink   (input valid, input status, input pos_x, input pos_y,
                  input cur_width, input cur_height, input used_height,
                  output ready);
endinterface

@@ rtl/core/sat_row_ram.sv @@
// Simple dual-port row table memory: one write, one registered read per cycle.
// No dependencies.
module sat_row_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 46,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/sat_ctrl.sv @@
// Placement sequencer: scans the row table, grows the atlas, opens rows.
// Depends on sat_pkg; drives the row table memory (sat_row_ram).
module sat_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  sat_pkg::cfg_t                cfg,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  logic [sat_pkg::SIDE_W-1:0]   rect_width,
  input  logic [sat_pkg::SIDE_W-1:0]   rect_height,
  output logic                         res_done,
  input  logic                         res_take,
  output sat_pkg::res_t                res,
  output logic                         ram_re,
  output logic [sat_pkg::ROW_AW-1:0]   ram_raddr,
  input  sat_pkg::row_t                ram_rdata,
  output logic                         ram_we,
  output logic [sat_pkg::ROW_AW-1:0]   ram_waddr,
  output sat_pkg::row_t                ram_wdata
);
  import sat_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_GROW = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state;

  logic [CNT_W-1:0]    row_count;
  logic [SIDE_W-1:0]   next_top;
  logic [SIDE_W-1:0]   atlas_w;
  logic [SIDE_W-1:0]   atlas_h;
  logic                dv;
  logic                found;

  logic [PAD_SZ_W-1:0] pw;
  logic [PAD_SZ_W-1:0] ph;
  logic [CNT_W-1:0]    rd_idx;
  logic [ROW_AW-1:0]   eval_idx;
  logic [ROW_AW-1:0]   best_idx;
  row_t                best;
  logic [6:0]          steps;
  logic [1:0]          r_status;
  logic [POS_W-1:0]    r_px;
  logic [POS_W-1:0]    r_py;

  logic                issue;
  logic                scan_end;
  logic [FILL_W:0]     fill_sum;
  logic                fits;
  logic                better;
  logic                take_row;
  logic                tbl_full;
  logic [SIDE_W-1:0]   mw;
  logic [SIDE_W-1:0]   mh;
  logic [SIDE_W-1:0]   nw;
  logic [SIDE_W-1:0]   nh;
  logic [SIDE_W+1:0]   top_sum;
  logic                grow_fit;
  logic                grow_stop;

  // scan datapath
  assign issue    = (state == S_SCAN) && (rd_idx < row_count);
  assign scan_end = (state == S_SCAN) && (rd_idx == row_count) && !dv;
  assign fill_sum = {1'b0, ram_rdata.fill} + {1'b0, pw};
  assign fits     = (fill_sum <= {2'b00, atlas_w}) && (ph <= {1'b0, ram_rdata.tall});
  assign better   = !found || (ram_rdata.tall < best.tall) ||
                    ((ram_rdata.tall == best.tall) && (ram_rdata.fill < best.fill));
  assign take_row = dv && fits && better;
  assign tbl_full = (row_count >= CNT_W'(MAX_ROWS));

  // growth datapath
  assign mw        = lim(cfg.max_width);
  assign mh        = lim(cfg.max_height);
  assign nw        = grow_side(atlas_w, mw);
  assign nh        = grow_side(atlas_h, mh);
  assign top_sum   = {2'b00, next_top} + {1'b0, ph};
  assign grow_fit  = (top_sum <= {2'b00, atlas_h}) && (pw <= {1'b0, atlas_w});
  assign grow_stop = ((atlas_w >= mw) && (atlas_h >= mh)) || steps[6] ||
                     ((nw == atlas_w) && (nh == atlas_h));

  // memory ports
  assign ram_re    = issue;
  assign ram_raddr = rd_idx[ROW_AW-1:0];

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = best_idx;
    ram_wdata = best;
    if ((state == S_SCAN) && scan_end && found) begin
      ram_we         = 1'b1;
      ram_wdata.fill = best.fill + pw;
    end else if ((state == S_GROW) && grow_fit) begin
      ram_we    = 1'b1;
      ram_waddr = row_count[ROW_AW-1:0];
      ram_wdata = '{top: next_top, tall: ph[SIDE_W-1:0], fill: pw};
    end
  end

  assign req_ready       = (state == S_IDLE);
  assign res_done        = (state == S_DONE);
  assign res.status      = r_status;
  assign res.pos_x       = r_px;
  assign res.pos_y       = r_py;
  assign res.cur_width   = atlas_w;
  assign res.cur_height  = atlas_h;
  assign res.used_height = next_top;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      row_count <= '0;
      next_top  <= '0;
      atlas_w   <= START_W_RST;
      atlas_h   <= START_H_RST;
      dv        <= 1'b0;
      found     <= 1'b0;
    end else begin
      if (cfg.load_w) begin
        atlas_w <= cfg.load_value;
      end
      if (cfg.load_h) begin
        atlas_h <= cfg.load_value;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_SCAN;
            dv    <= 1'b0;
            found <= 1'b0;
          end
        end
        S_SCAN: begin
          dv <= issue;
          if (take_row) begin
            found <= 1'b1;
          end
          if (scan_end) begin
            state <= (found || tbl_full) ? S_DONE : S_GROW;
          end
        end
        S_GROW: begin
          if (grow_fit) begin
            row_count <= row_count + 1'b1;
            next_top  <= next_top + ph[SIDE_W-1:0];
            state     <= S_DONE;
          end else if (grow_stop) begin
            state <= S_DONE;
          end else begin
            atlas_w <= nw;
            atlas_h <= nh;
          end
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // per-item payload
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        pw     <= {1'b0, rect_width} + {2'b00, cfg.pad_amount};
        ph     <= {1'b0, rect_height} + {2'b00, cfg.pad_amount};
        rd_idx <= '0;
        steps  <= '0;
      end
      S_SCAN: begin
        if (issue) begin
          rd_idx   <= rd_idx + 1'b1;
          eval_idx <= rd_idx[ROW_AW-1:0];
        end
        if (take_row) begin
          best_idx <= eval_idx;
          best     <= ram_rdata;
        end
        if (scan_end) begin
          if (found) begin
            r_status <= ST_PLACED;
            r_px     <= best.fill[POS_W-1:0];
            r_py     <= best.top[POS_W-1:0];
          end else begin
            r_status <= ST_FULL;
            r_px     <= '0;
            r_py     <= '0;
          end
        end
      end
      S_GROW: begin
        if (grow_fit) begin
          r_status <= ST_PLACED;
          r_px     <= '0;
          r_py     <= next_top[POS_W-1:0];
        end else if (grow_stop) begin
          r_status <= ST_AT_MAX;
          r_px     <= '0;
          r_py     <= '0;
        end else begin
          steps <= steps + 1'b1;
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/core/shelf_atlas_allocator.sv @@
// Shelf atlas allocator top level: configuration registers, result register,
// sequencer and row table. Depends on sat_pkg, sat_req_if, sat_res_if,
// sat_ctrl and sat_row_ram.
//
//  channel  dir  handshake            payload
//  -------  ---  -------------------  -------------------------------------------
//  req      in   req.valid/req.ready  rect_width, rect_height
//  res      out  res.valid/res.ready  status, pos_x, pos_y, cur_width,
//                                     cur_height, used_height
//  cfg      in   cfg_wen              cfg_index, cfg_data (write only)
//
// One item at a time. The row table is read one row per cycle through the single
// read port of the row memory. When no row fits, the sequencer opens a new row,
// doubling the atlas step by step until the row fits or growth stops.
// Reset is synchronous; the row table holds no valid bits, only rows below
// row_count are ever read. The result sits in an output register, so a
// stalled res channel lets the next item be taken and worked on; that item
// then waits in its last state until the register frees up.
module shelf_atlas_allocator (
  input  logic                        clk,
  input  logic                        rst,
  sat_req_if.sink                     req,
  sat_res_if.source                   res,
  input  logic                        cfg_wen,
  input  logic [sat_pkg::CFG_AW-1:0]  cfg_index,
  input  logic [sat_pkg::CFG_DW-1:0]  cfg_data
);
  import sat_pkg::*;

  // configuration registers
  logic [SIDE_W-1:0] max_width;
  logic [SIDE_W-1:0] max_height;
  logic [PAD_W-1:0]  pad_amount;
  cfg_t              cfg;

  // result register
  logic              out_valid;
  res_t              out_res;

  // sequencer <-> top
  logic              res_done;
  logic              res_take;
  res_t              ctrl_res;

  // row memory
  logic              ram_re;
  logic [ROW_AW-1:0] ram_raddr;
  row_t              ram_rdata;
  logic              ram_we;
  logic [ROW_AW-1:0] ram_waddr;
  row_t              ram_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_width  <= MAX_W_RST;
      max_height <= MAX_H_RST;
      pad_amount <= PAD_RST;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_MAX_W: max_width  <= cfg_data;
        REG_MAX_H: max_height <= cfg_data;
        REG_PAD:   pad_amount <= cfg_data[PAD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // start size writes also load the live atlas size in the sequencer
  always_comb begin
    cfg.max_width  = max_width;
    cfg.max_height = max_height;
    cfg.pad_amount = pad_amount;
    cfg.load_w     = cfg_wen && (cfg_index == REG_START_W);
    cfg.load_h     = cfg_wen && (cfg_index == REG_START_H);
    cfg.load_value = cfg_data;
  end

  // result register: loads when empty or being drained this cycle
  assign res_take = res_done && (!out_valid || res.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res <= ctrl_res;
    end
  end

  assign res.valid       = out_valid;
  assign res.status      = out_res.status;
  assign res.pos_x       = out_res.pos_x;
  assign res.pos_y       = out_res.pos_y;
  assign res.cur_width   = out_res.cur_width;
  assign res.cur_height  = out_res.cur_height;
  assign res.used_height = out_res.used_height;

  sat_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rect_width  (req.rect_width),
    .rect_height (req.rect_height),
    .res_done    (res_done),
    .res_take    (res_take),
    .res         (ctrl_res),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata)
  );

  sat_row_ram #(
    .DEPTH (MAX_ROWS),
    .WIDTH ($bits(row_t)),
    .AW    (ROW_AW)
  ) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

@@ rtl/core/sat_checker.sv @@
// Port-level checks of the shelf atlas allocator, bound to the top level.
// Depends on sat_pkg and shelf_atlas_allocator_macros.svh.
`include "shelf_atlas_allocator_macros.svh"

module sat_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input logic                       res_valid,
  input logic                       res_ready,
  input logic [1:0]                 status,
  input logic [sat_pkg::POS_W-1:0]  pos_x,
  input logic [sat_pkg::POS_W-1:0]  pos_y,
  input logic [sat_pkg::SIDE_W-1:0] cur_width,
  input logic [sat_pkg::SIDE_W-1:0] cur_height,
  input logic [sat_pkg::SIDE_W-1:0] used_height
);
  import sat_pkg::*;

  // a held result keeps its payload
  `SAT_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(status) && $stable(pos_x) && $stable(pos_y) && $stable(cur_width) && $stable(cur_height) && $stable(used_height), "result changed while stalled")

  // one item in flight: ready drops right after an accept
  `SAT_ASSERT_NEXT(a_one_item, req_valid && req_ready, !req_ready, "second item taken while busy")

  // a placed rectangle starts inside the atlas and inside the used rows
  `SAT_ASSERT_NOW(a_placed_in, res_valid && (status == ST_PLACED), ({1'b0, pos_x} <= cur_width) && ({1'b0, pos_y} <= used_height), "placement outside atlas")

  // failed requests report the origin
  `SAT_ASSERT_NOW(a_fail_zero, res_valid && (status != ST_PLACED), (pos_x == '0) && (pos_y == '0), "failed request with nonzero position")

endmodule

bind shelf_atlas_allocator sat_checker u_sat_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .status      (res.status),
  .pos_x       (res.pos_x),
  .pos_y       (res.pos_y),
  .cur_width   (res.cur_width),
  .cur_height  (res.cur_height),
  .used_height (res.used_height)
);
